/* sv/ple_pkg.sv */
package ple_pkg;

	localparam int CAPACITY_DEF  = 16;
	localparam int WORD_BITS_DEF = 32;

	localparam int KIND_BITS = 3;
	localparam int POS_BITS  = 5;
	localparam int DATA_BITS = 32;
	localparam int FILL_BITS = 5;

	typedef enum logic [KIND_BITS-1:0] {
		KIND_PUSH_FRONT = 3'd0,
		KIND_PUSH_BACK  = 3'd1,
		KIND_INSERT_AT  = 3'd2,
		KIND_POP_FRONT  = 3'd3,
		KIND_POP_BACK   = 3'd4,
		KIND_REMOVE_AT  = 3'd5,
		KIND_READ_AT    = 3'd6,
		KIND_REPLACE_AT = 3'd7
	} kind_t;

	// slot row commands, at most one set per cycle
	typedef struct packed {
		logic open;
		logic close;
		logic write;
	} slot_ctrl_t;

endpackage

/* sv/ple_slots.sv */
module ple_slots #(
	parameter int CAPACITY  = ple_pkg::CAPACITY_DEF,
	parameter int WORD_BITS = ple_pkg::WORD_BITS_DEF,
	parameter int IW        = $clog2(CAPACITY)
) (
	input  logic                  clk,
	input  ple_pkg::slot_ctrl_t   ctrl,
	input  logic [IW-1:0]         at,
	input  logic [WORD_BITS-1:0]  wr_word,
	output logic [WORD_BITS-1:0]  rd_word
);
	import ple_pkg::*;

	logic [WORD_BITS-1:0] slot_q [CAPACITY];

	// read port sees the row before this cycle's shift
	assign rd_word = slot_q[at];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [WORD_BITS-1:0] prev_w;
		logic [WORD_BITS-1:0] next_w;
		logic                 hit;
		logic                 behind;

		if (i == 0) begin : g_first
			assign prev_w = slot_q[i];
		end else begin : g_prev
			assign prev_w = slot_q[i-1];
		end
		if (i == CAPACITY-1) begin : g_last
			assign next_w = slot_q[i];
		end else begin : g_next
			assign next_w = slot_q[i+1];
		end

		assign hit    = (IW'(i) == at);
		assign behind = (IW'(i) > at);

		always_ff @(posedge clk) begin
			if (ctrl.open) begin
				if (hit) begin
					slot_q[i] <= wr_word;
				end else if (behind) begin
					slot_q[i] <= prev_w;
				end
			end else if (ctrl.close) begin
				if (hit || behind) begin
					slot_q[i] <= next_w;
				end
			end else if (ctrl.write && hit) begin
				slot_q[i] <= wr_word;
			end
		end
	end

endmodule

/* sv/positional_list_engine_unit.sv */
// Bounded ordered list of words held in a row of shiftable slots.
// Input channel (in_valid/in_ready) carries one request: kind, position, value.
// Output channel (out_valid/out_ready) returns one result per request: ok,
// data_out (word read or removed, zero otherwise) and fill_count afterwards.
// A request lands in an input register when it is accepted; once it advances,
// the operation runs, shifts the slot row in one step and loads the result
// register, which offers the result on the output channel.
// Throughput is one item per cycle: the slot row and the count update
// together, and the input stage moves on whenever the result register is
// empty or being taken in the same cycle.
// A refused request (full, empty, position out of range) leaves the list as
// it was and returns ok low.
// When the receiver stalls, the result holds; one more item waits in the
// input register, after which in_ready drops.
// Reset clears the count and both valid flags; slot contents are left as
// they are and only ever read below the count.
module positional_list_engine_unit #(
	parameter int CAPACITY  = ple_pkg::CAPACITY_DEF,
	parameter int WORD_BITS = ple_pkg::WORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ple_pkg::KIND_BITS-1:0] kind,
	input  logic [ple_pkg::POS_BITS-1:0]  position,
	input  logic [ple_pkg::DATA_BITS-1:0] value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          ok,
	output logic [ple_pkg::DATA_BITS-1:0] data_out,
	output logic [ple_pkg::FILL_BITS-1:0] fill_count
);
	import ple_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int MW = (CW > POS_BITS) ? CW : POS_BITS;

	logic                 valid_s1;
	logic [KIND_BITS-1:0] kind_s1;
	logic [POS_BITS-1:0]  pos_s1;
	logic [DATA_BITS-1:0] value_s1;

	logic [CW-1:0]        count_q;
	logic                 out_valid_q;
	logic                 ok_q;
	logic [DATA_BITS-1:0] data_q;
	logic [CW-1:0]        fill_q;

	logic                 advance;
	logic [MW-1:0]        cnt_m;
	logic [MW-1:0]        pos_m;
	logic [MW-1:0]        at_m;
	logic                 not_full;
	logic                 not_empty;
	logic                 req_ok;
	logic                 gives_data;
	slot_ctrl_t           ctrl;
	logic [WORD_BITS-1:0] wr_word;
	logic [WORD_BITS-1:0] rd_word;
	logic [63:0]          rd_wide;
	logic [CW-1:0]        count_nx;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1  <= kind;
			pos_s1   <= position;
			value_s1 <= value;
		end
	end

	assign cnt_m     = MW'(count_q);
	assign pos_m     = MW'(pos_s1);
	assign not_full  = (cnt_m < MW'(CAPACITY));
	assign not_empty = (count_q != '0);

	always_comb begin
		at_m       = '0;
		req_ok     = 1'b0;
		gives_data = 1'b0;
		ctrl       = '0;
		case (kind_s1)
			KIND_PUSH_FRONT: begin
				req_ok    = not_full;
				ctrl.open = advance && req_ok;
			end
			KIND_PUSH_BACK: begin
				at_m      = cnt_m;
				req_ok    = not_full;
				ctrl.open = advance && req_ok;
			end
			KIND_INSERT_AT: begin
				at_m      = pos_m;
				req_ok    = not_full && (pos_m <= cnt_m);
				ctrl.open = advance && req_ok;
			end
			KIND_POP_FRONT: begin
				req_ok     = not_empty;
				gives_data = 1'b1;
				ctrl.close = advance && req_ok;
			end
			KIND_POP_BACK: begin
				at_m       = cnt_m - MW'(1);
				req_ok     = not_empty;
				gives_data = 1'b1;
				ctrl.close = advance && req_ok;
			end
			KIND_REMOVE_AT: begin
				at_m       = pos_m;
				req_ok     = (pos_m < cnt_m);
				gives_data = 1'b1;
				ctrl.close = advance && req_ok;
			end
			KIND_READ_AT: begin
				at_m       = pos_m;
				req_ok     = (pos_m < cnt_m);
				gives_data = 1'b1;
			end
			KIND_REPLACE_AT: begin
				at_m       = pos_m;
				req_ok     = (pos_m < cnt_m);
				ctrl.write = advance && req_ok;
			end
			default: begin
				req_ok = 1'b0;
			end
		endcase
	end

	assign wr_word = WORD_BITS'(value_s1);

	ple_slots #(
		.CAPACITY  (CAPACITY),
		.WORD_BITS (WORD_BITS),
		.IW        (IW)
	) u_slots (
		.clk     (clk),
		.ctrl    (ctrl),
		.at      (at_m[IW-1:0]),
		.wr_word (wr_word),
		.rd_word (rd_word)
	);

	assign rd_wide = 64'(rd_word);

	always_comb begin
		count_nx = count_q;
		if (ctrl.open) begin
			count_nx = count_q + CW'(1);
		end else if (ctrl.close) begin
			count_nx = count_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_nx;
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ok_q   <= req_ok;
			data_q <= (req_ok && gives_data) ? rd_wide[DATA_BITS-1:0] : '0;
			fill_q <= count_nx;
		end
	end

	assign out_valid  = out_valid_q;
	assign ok         = ok_q;
	assign data_out   = data_q;
	assign fill_count = FILL_BITS'(fill_q);

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		MW'(count_q) <= MW'(CAPACITY))
		else $error("item count above capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.open |=> count_q == $past(count_q) + CW'(1))
		else $error("count did not grow after insert");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !ok_q |-> data_q == '0)
		else $error("refused item carries data");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with empty result register");
`endif

endmodule
